/* src/toroidal_life_generation_engine_defines.svh */
// Assertion macros shared by the life engine RTL.
// Depends on nothing; included by files that carry concurrent checks.
`ifndef TOROIDAL_LIFE_GENERATION_ENGINE_DEFINES_SVH
`define TOROIDAL_LIFE_GENERATION_ENGINE_DEFINES_SVH

// Same-cycle implication check.
`define TLG_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication check.
`define TLG_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* src/tlg_pkg.sv */
// Shared types and constants for the toroidal life engine.
// No dependencies; used by every module of the block.
package tlg_pkg;

    localparam int DEF_BOARD_COLS = 160;
    localparam int DEF_BOARD_ROWS = 90;

    localparam int FUNC_W = 2;
    localparam int COL_W  = 8;
    localparam int ROW_W  = 7;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_WRITE   = 2'd0,
        FUNC_INVERT  = 2'd1,
        FUNC_ADVANCE = 2'd2,
        FUNC_READ    = 2'd3
    } func_t;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_CELL_RD,
        S_CELL_WR,
        S_PRE,
        S_LOAD,
        S_SWEEP,
        S_ROW_END,
        S_FINISH
    } state_t;

    typedef struct packed {
        logic re;
        logic we_a;
        logic we_b;
    } store_ctrl_t;

    typedef struct packed {
        logic load;
        logic step;
    } win_ctrl_t;

endpackage

/* src/toroidal_life_generation_engine.sv */
// Top level of the toroidal B3/S23 life engine: request decode and sequencer.
// Depends on tlg_pkg, tlg_board_store, tlg_gen_window and the assertion macros.
//
//  channel   | ports                               | handshake
//  ----------+-------------------------------------+------------------------------
//  request   | func, col, row, value               | taken when start & !busy
//  result    | cell_state, op_done                 | result_valid, one cycle
//
// A write, invert or read request keeps busy high through a row read and a row
// write-back; the result strobe comes in the cycle after.
// An advance keeps busy high while the window is primed with three rows and then
// sweeps one cell per cycle, with a row write-back and a fetch of the row two
// ahead at the end of each row, and a final bank swap.
// After reset a clearing pass over every row zeroes both boards; busy is
// high meanwhile. The receiver cannot stall: each result shows for one cycle.
`include "toroidal_life_generation_engine_defines.svh"

module toroidal_life_generation_engine #(
    parameter int BOARD_COLS = tlg_pkg::DEF_BOARD_COLS,
    parameter int BOARD_ROWS = tlg_pkg::DEF_BOARD_ROWS
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [tlg_pkg::FUNC_W-1:0]  func,
    input  logic [tlg_pkg::COL_W-1:0]   col,
    input  logic [tlg_pkg::ROW_W-1:0]   row,
    input  logic                        value,
    output logic                        busy,
    output logic                        result_valid,
    output logic                        cell_state,
    output logic                        op_done
);

    localparam int CIW = $clog2(BOARD_COLS);
    localparam int RAW = $clog2(BOARD_ROWS);

    localparam logic [CIW-1:0] LastCol = CIW'(BOARD_COLS - 1);
    localparam logic [RAW-1:0] LastRow = RAW'(BOARD_ROWS - 1);
    localparam logic [RAW:0]   RowSpan = (RAW+1)'(BOARD_ROWS);

    tlg_pkg::state_t state_reg, state_next;
    tlg_pkg::func_t  func_reg, func_next;
    logic [CIW-1:0]  col_reg, col_next;
    logic [RAW-1:0]  row_reg, row_next;
    logic            value_reg, value_next;
    logic [1:0]      pre_reg, pre_next;
    logic            fetch_reg, fetch_next;
    logic            bank_reg, bank_next;
    logic            valid_reg, valid_next;
    logic            cstate_reg, cstate_next;

    tlg_pkg::store_ctrl_t  sctl;
    tlg_pkg::win_ctrl_t    wctl;
    logic [RAW-1:0]        raddr;
    logic [RAW-1:0]        waddr;
    logic [BOARD_COLS-1:0] wdata;
    logic [BOARD_COLS-1:0] rdata;
    logic [BOARD_COLS-1:0] new_row;
    logic [BOARD_COLS-1:0] word_mod;
    logic                  new_bit;
    logic [CIW-1:0]        col_sel;
    logic [RAW-1:0]        row_sel;
    logic [RAW:0]          row_plus2;
    logic [RAW-1:0]        row_ahead;

    tlg_board_store #(
        .BOARD_COLS (BOARD_COLS),
        .BOARD_ROWS (BOARD_ROWS)
    ) u_store (
        .clk   (clk),
        .ctrl  (sctl),
        .bank  (bank_reg),
        .raddr (raddr),
        .waddr (waddr),
        .wdata (wdata),
        .rdata (rdata)
    );

    tlg_gen_window #(
        .BOARD_COLS (BOARD_COLS)
    ) u_window (
        .clk     (clk),
        .ctrl    (wctl),
        .row_in  (rdata),
        .row_out (new_row)
    );

    // out-of-range coordinates address column or row zero
    assign col_sel = (int'(col) < BOARD_COLS) ? CIW'(col) : '0;
    assign row_sel = (int'(row) < BOARD_ROWS) ? RAW'(row) : '0;

    always_comb
    begin
        row_plus2 = {1'b0, row_reg} + (RAW+1)'(2);
        if (row_plus2 >= RowSpan)
        begin
            row_plus2 = row_plus2 - RowSpan;
        end
        row_ahead = row_plus2[RAW-1:0];
    end

    always_comb
    begin
        new_bit  = (func_reg == tlg_pkg::FUNC_WRITE) ? value_reg : ~rdata[col_reg];
        word_mod = rdata;
        word_mod[col_reg] = new_bit;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= tlg_pkg::S_CLEAR;
            func_reg   <= tlg_pkg::FUNC_WRITE;
            col_reg    <= '0;
            row_reg    <= '0;
            value_reg  <= 1'b0;
            pre_reg    <= 2'd0;
            fetch_reg  <= 1'b0;
            bank_reg   <= 1'b0;
            valid_reg  <= 1'b0;
            cstate_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            func_reg   <= func_next;
            col_reg    <= col_next;
            row_reg    <= row_next;
            value_reg  <= value_next;
            pre_reg    <= pre_next;
            fetch_reg  <= fetch_next;
            bank_reg   <= bank_next;
            valid_reg  <= valid_next;
            cstate_reg <= cstate_next;
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        func_next   = func_reg;
        col_next    = col_reg;
        row_next    = row_reg;
        value_next  = value_reg;
        pre_next    = pre_reg;
        fetch_next  = 1'b0;
        bank_next   = bank_reg;
        valid_next  = 1'b0;
        cstate_next = cstate_reg;

        sctl      = '0;
        wctl.load = fetch_reg;
        wctl.step = 1'b0;
        raddr     = row_reg;
        waddr     = row_reg;
        wdata     = new_row;

        case (state_reg)
            tlg_pkg::S_CLEAR:
            begin
                sctl.we_a = 1'b1;
                sctl.we_b = 1'b1;
                wdata     = '0;
                if (row_reg == LastRow)
                begin
                    row_next   = '0;
                    state_next = tlg_pkg::S_IDLE;
                end
                else
                begin
                    row_next = row_reg + RAW'(1);
                end
            end

            tlg_pkg::S_IDLE:
            begin
                if (start)
                begin
                    func_next  = tlg_pkg::func_t'(func);
                    value_next = value;
                    if (tlg_pkg::func_t'(func) == tlg_pkg::FUNC_ADVANCE)
                    begin
                        col_next   = '0;
                        row_next   = '0;
                        pre_next   = 2'd0;
                        state_next = tlg_pkg::S_PRE;
                    end
                    else
                    begin
                        col_next   = col_sel;
                        row_next   = row_sel;
                        state_next = tlg_pkg::S_CELL_RD;
                    end
                end
            end

            tlg_pkg::S_CELL_RD:
            begin
                sctl.re    = 1'b1;
                state_next = tlg_pkg::S_CELL_WR;
            end

            tlg_pkg::S_CELL_WR:
            begin
                wdata = word_mod;
                if (func_reg == tlg_pkg::FUNC_READ)
                begin
                    cstate_next = rdata[col_reg];
                end
                else
                begin
                    sctl.we_a   = ~bank_reg;
                    sctl.we_b   = bank_reg;
                    cstate_next = new_bit;
                end
                valid_next = 1'b1;
                state_next = tlg_pkg::S_IDLE;
            end

            tlg_pkg::S_PRE:
            begin
                // prime the window with the last, first and second rows
                sctl.re    = 1'b1;
                fetch_next = 1'b1;
                case (pre_reg)
                    2'd0:    raddr = LastRow;
                    2'd1:    raddr = '0;
                    default: raddr = RAW'(1);
                endcase
                if (pre_reg == 2'd2)
                begin
                    state_next = tlg_pkg::S_LOAD;
                end
                else
                begin
                    pre_next = pre_reg + 2'd1;
                end
            end

            tlg_pkg::S_LOAD:
            begin
                state_next = tlg_pkg::S_SWEEP;
            end

            tlg_pkg::S_SWEEP:
            begin
                wctl.step = 1'b1;
                if (col_reg == LastCol)
                begin
                    col_next   = '0;
                    state_next = tlg_pkg::S_ROW_END;
                end
                else
                begin
                    col_next = col_reg + CIW'(1);
                end
            end

            tlg_pkg::S_ROW_END:
            begin
                // write the finished row to the spare board, fetch two rows ahead
                sctl.we_a = bank_reg;
                sctl.we_b = ~bank_reg;
                if (row_reg == LastRow)
                begin
                    state_next = tlg_pkg::S_FINISH;
                end
                else
                begin
                    sctl.re    = 1'b1;
                    raddr      = row_ahead;
                    fetch_next = 1'b1;
                    row_next   = row_reg + RAW'(1);
                    state_next = tlg_pkg::S_LOAD;
                end
            end

            tlg_pkg::S_FINISH:
            begin
                bank_next   = ~bank_reg;
                row_next    = '0;
                cstate_next = 1'b0;
                valid_next  = 1'b1;
                state_next  = tlg_pkg::S_IDLE;
            end

            default:
            begin
                state_next = tlg_pkg::S_IDLE;
            end
        endcase
    end

    assign busy         = (state_reg != tlg_pkg::S_IDLE);
    assign result_valid = valid_reg;
    assign cell_state   = cstate_reg;
    assign op_done      = valid_reg;

    `TLG_ASSERT_NOW(a_result_in_idle, clk, rst_n, result_valid, state_reg == tlg_pkg::S_IDLE, "result strobe outside idle")
    `TLG_ASSERT_NEXT(a_accept_busy, clk, rst_n, start && !busy, busy, "accepted request left block idle")
    `TLG_ASSERT_NOW(a_dual_write, clk, rst_n, sctl.we_a && sctl.we_b, state_reg == tlg_pkg::S_CLEAR, "both boards written outside clearing")
    `TLG_ASSERT_NOW(a_bank_flip, clk, rst_n, bank_reg != $past(bank_reg), $past(state_reg) == tlg_pkg::S_FINISH, "bank changed outside generation end")
    `TLG_ASSERT_NOW(a_window_excl, clk, rst_n, wctl.load, !wctl.step, "window load and step overlap")

endmodule

/* src/tlg_board_store.sv */
// Two row-wide board memories, one row per entry, registered read port.
// Depends on tlg_pkg for the control struct.
module tlg_board_store #(
    parameter int BOARD_COLS = tlg_pkg::DEF_BOARD_COLS,
    parameter int BOARD_ROWS = tlg_pkg::DEF_BOARD_ROWS,
    localparam int RAW = $clog2(BOARD_ROWS)
) (
    input  logic                    clk,
    input  tlg_pkg::store_ctrl_t    ctrl,
    input  logic                    bank,
    input  logic [RAW-1:0]          raddr,
    input  logic [RAW-1:0]          waddr,
    input  logic [BOARD_COLS-1:0]   wdata,
    output logic [BOARD_COLS-1:0]   rdata
);

    logic [BOARD_COLS-1:0] board_a [BOARD_ROWS];
    logic [BOARD_COLS-1:0] board_b [BOARD_ROWS];

    logic [BOARD_COLS-1:0] rd_a_reg;
    logic [BOARD_COLS-1:0] rd_b_reg;

    always_ff @(posedge clk)
    begin
        if (ctrl.we_a)
        begin
            board_a[waddr] <= wdata;
        end
        if (ctrl.re)
        begin
            rd_a_reg <= board_a[raddr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.we_b)
        begin
            board_b[waddr] <= wdata;
        end
        if (ctrl.re)
        begin
            rd_b_reg <= board_b[raddr];
        end
    end

    // bank is steady between a read and the use of its data
    assign rdata = bank ? rd_b_reg : rd_a_reg;

endmodule

/* src/tlg_gen_window.sv */
// Three-row sliding window and next-row builder for one generation step.
// Depends on tlg_pkg for the control struct.
module tlg_gen_window #(
    parameter int BOARD_COLS = tlg_pkg::DEF_BOARD_COLS
) (
    input  logic                    clk,
    input  tlg_pkg::win_ctrl_t      ctrl,
    input  logic [BOARD_COLS-1:0]   row_in,
    output logic [BOARD_COLS-1:0]   row_out
);

    logic [BOARD_COLS-1:0] up_reg;
    logic [BOARD_COLS-1:0] mid_reg;
    logic [BOARD_COLS-1:0] dn_reg;
    logic [BOARD_COLS-1:0] res_reg;

    logic [3:0] ncount;
    logic       alive;
    logic       next_alive;

    // position 0 is the current column, 1 its right and the top bit its left neighbor
    always_comb
    begin
        ncount = {3'b000, up_reg[BOARD_COLS-1]} + {3'b000, up_reg[0]}
               + {3'b000, up_reg[1]}           + {3'b000, mid_reg[BOARD_COLS-1]}
               + {3'b000, mid_reg[1]}          + {3'b000, dn_reg[BOARD_COLS-1]}
               + {3'b000, dn_reg[0]}           + {3'b000, dn_reg[1]};
        alive      = mid_reg[0];
        next_alive = (ncount == 4'd3) || (alive && (ncount == 4'd2));
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load)
        begin
            up_reg  <= mid_reg;
            mid_reg <= dn_reg;
            dn_reg  <= row_in;
        end
        else if (ctrl.step)
        begin
            // rotate right; after a full row the rows are back in place
            up_reg  <= {up_reg[0],  up_reg[BOARD_COLS-1:1]};
            mid_reg <= {mid_reg[0], mid_reg[BOARD_COLS-1:1]};
            dn_reg  <= {dn_reg[0],  dn_reg[BOARD_COLS-1:1]};
            res_reg <= {next_alive, res_reg[BOARD_COLS-1:1]};
        end
    end

    assign row_out = res_reg;

endmodule
